// File: design/dwpd_pkg.sv
// Shared widths, register codes, reset values and types of the dual wheel drive.
package dwpd_pkg;

    localparam int POS_W       = 32;
    localparam int GAIN_W      = 12;
    localparam int ILIM_W      = 15;
    localparam int OLIM_W      = 8;
    localparam int INTEG_W     = 16;
    localparam int DRIVE_W     = 9;
    localparam int DUTY_W      = 8;
    localparam int DIFF_W      = POS_W + 1;
    localparam int PROD_W      = DIFF_W + GAIN_W + 1;
    localparam int ISUM_W      = PROD_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int DRIVE_SHIFT = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ILIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_I_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd4;

    localparam logic [GAIN_W-1:0] RESET_P_GAIN    = 12'd200;
    localparam logic [GAIN_W-1:0] RESET_I_GAIN    = 12'd25;
    localparam logic [GAIN_W-1:0] RESET_D_GAIN    = 12'd240;
    localparam logic [ILIM_W-1:0] RESET_I_LIMIT   = 15'd128;
    localparam logic [OLIM_W-1:0] RESET_OUT_LIMIT = 8'd150;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

    typedef struct packed {
        logic [GAIN_W-1:0] proportional_gain;
        logic [GAIN_W-1:0] integral_gain;
        logic [GAIN_W-1:0] derivative_gain;
        logic [ILIM_W-1:0] integral_limit;
        logic [OLIM_W-1:0] output_limit;
    } gains_t;

    // Pipeline control shared by both wheels.
    typedef struct packed {
        logic advance;
        logic in_valid;
        logic s1_valid;
        logic s2_valid;
    } stage_ctl_t;

endpackage

// File: design/dwpd_wheel.sv
// One wheel: difference, multiply and accumulate/clamp/duty stages.
module dwpd_wheel (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dwpd_pkg::stage_ctl_t                  ctl,
    input  dwpd_pkg::gains_t                      gains,
    input  logic signed [dwpd_pkg::POS_W-1:0]     position,
    input  logic signed [dwpd_pkg::POS_W-1:0]     target,
    output logic signed [dwpd_pkg::DRIVE_W-1:0]   drive,
    output logic        [dwpd_pkg::DUTY_W-1:0]    duty_a,
    output logic        [dwpd_pkg::DUTY_W-1:0]    duty_b
);
    import dwpd_pkg::*;

    logic signed [POS_W-1:0]   prev_reg;
    logic signed [DIFF_W-1:0]  vel_reg;
    logic signed [DIFF_W-1:0]  err_reg;
    logic signed [PROD_W-1:0]  pterm_reg;
    logic signed [PROD_W-1:0]  iterm_reg;
    logic signed [PROD_W-1:0]  dterm_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic [DUTY_W-1:0]         duty_a_reg;
    logic [DUTY_W-1:0]         duty_b_reg;
    logic [DUTY_W-1:0]         duty_a_next;
    logic [DUTY_W-1:0]         duty_b_next;

    logic signed [ISUM_W-1:0]  integ_sum;
    logic signed [ISUM_W-1:0]  ilim_s;
    logic signed [ISUM_W-1:0]  integ_clamp;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   bias;
    logic signed [SUM_W-1:0]   quot;
    logic signed [SUM_W-1:0]   olim_s;
    logic signed [SUM_W-1:0]   drive_clamp;
    logic signed [DRIVE_W-1:0] drive_neg;

    logic s1_en;
    logic s2_en;
    logic s3_en;

    assign s1_en = ctl.advance && ctl.in_valid;
    assign s2_en = ctl.advance && ctl.s1_valid;
    assign s3_en = ctl.advance && ctl.s2_valid;

    // Stage 1: velocity and error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (s1_en)
        begin
            prev_reg <= position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            vel_reg <= DIFF_W'(prev_reg) - DIFF_W'(position);
            err_reg <= DIFF_W'(position) - DIFF_W'(target);
        end
    end

    // Stage 2: gain products
    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            pterm_reg <= PROD_W'(err_reg) *
                         PROD_W'(signed'({1'b0, gains.proportional_gain}));
            iterm_reg <= PROD_W'(err_reg) *
                         PROD_W'(signed'({1'b0, gains.integral_gain}));
            dterm_reg <= PROD_W'(vel_reg) *
                         PROD_W'(signed'({1'b0, gains.derivative_gain}));
        end
    end

    // Stage 3: integral clamp, drive, duty mapping
    always_comb
    begin
        integ_sum = ISUM_W'(integ_reg) + ISUM_W'(iterm_reg);
        ilim_s    = signed'(ISUM_W'(gains.integral_limit));
        if (integ_sum > ilim_s)
            integ_clamp = ilim_s;
        else if (integ_sum < -ilim_s)
            integ_clamp = -ilim_s;
        else
            integ_clamp = integ_sum;
        integ_next = integ_clamp[INTEG_W-1:0];

        total = SUM_W'(pterm_reg) + SUM_W'(integ_next) - SUM_W'(dterm_reg);
        // truncate toward zero: bias negative sums before the arithmetic shift
        bias = '0;
        bias[DRIVE_SHIFT-1:0] = {DRIVE_SHIFT{total[SUM_W-1]}};
        quot = (total + bias) >>> DRIVE_SHIFT;

        olim_s = signed'(SUM_W'(gains.output_limit));
        if (quot > olim_s)
            drive_clamp = olim_s;
        else if (quot < -olim_s)
            drive_clamp = -olim_s;
        else
            drive_clamp = quot;
        drive_next = drive_clamp[DRIVE_W-1:0];
        drive_neg  = -drive_next;

        duty_a_next = duty_a_reg;
        duty_b_next = duty_b_reg;
        if (drive_next > 0)
        begin
            duty_a_next = DUTY_FULL - drive_next[DUTY_W-1:0];
            duty_b_next = DUTY_FULL;
        end
        else if (drive_next < 0)
        begin
            duty_a_next = DUTY_FULL;
            duty_b_next = DUTY_FULL - drive_neg[DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg  <= '0;
            duty_a_reg <= '0;
            duty_b_reg <= '0;
        end
        else if (s3_en)
        begin
            integ_reg  <= integ_next;
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive  = drive_reg;
    assign duty_a = duty_a_reg;
    assign duty_b = duty_b_reg;

endmodule

// File: design/dual_wheel_pid_pwm_drive.sv
// Top level: dual wheel PID position controller with PWM duty outputs.
// Each request carries the encoder and commanded positions of both wheels
// and yields one result with the clamped drive and two sign-magnitude PWM
// duties per wheel. A request is taken every cycle while no finished result
// is stalled; its result passes the three register stages of each wheel
// (position differences loaded at the accepting edge, gain products,
// integral clamp with drive and duty mapping). A stalled result holds the
// whole pipeline. When a wheel's drive is zero its duties keep their previous
// values (zero after reset). The user must write gains and limits through the
// cfg port only while no request is in flight; the block does not enforce it.
module dual_wheel_pid_pwm_drive (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // right_position, left_position, right_target, left_target
    input  logic [127:0]                        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // right_drive, left_drive, right_duty_a, right_duty_b,
    // left_duty_a, left_duty_b, zero pad
    output logic [55:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic [dwpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dwpd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dwpd_pkg::*;

    gains_t     gains_reg;
    stage_ctl_t ctl;
    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       s3_valid_reg;
    logic       advance;

    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;
    logic [DUTY_W-1:0]         right_duty_a;
    logic [DUTY_W-1:0]         right_duty_b;
    logic [DUTY_W-1:0]         left_duty_a;
    logic [DUTY_W-1:0]         left_duty_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.proportional_gain <= RESET_P_GAIN;
            gains_reg.integral_gain     <= RESET_I_GAIN;
            gains_reg.derivative_gain   <= RESET_D_GAIN;
            gains_reg.integral_limit    <= RESET_I_LIMIT;
            gains_reg.output_limit      <= RESET_OUT_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_P_GAIN:    gains_reg.proportional_gain <= cfg_data[GAIN_W-1:0];
                REG_I_GAIN:    gains_reg.integral_gain     <= cfg_data[GAIN_W-1:0];
                REG_D_GAIN:    gains_reg.derivative_gain   <= cfg_data[GAIN_W-1:0];
                REG_I_LIMIT:   gains_reg.integral_limit    <= cfg_data[ILIM_W-1:0];
                REG_OUT_LIMIT: gains_reg.output_limit      <= cfg_data[OLIM_W-1:0];
                default:       ;
            endcase
        end
    end

    // whole pipeline moves unless a finished result is stalled
    assign advance  = !s3_valid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign ctl.advance  = advance;
    assign ctl.in_valid = s_tvalid;
    assign ctl.s1_valid = s1_valid_reg;
    assign ctl.s2_valid = s2_valid_reg;

    dwpd_wheel u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .gains    (gains_reg),
        .position (signed'(s_tdata[31:0])),
        .target   (signed'(s_tdata[95:64])),
        .drive    (right_drive),
        .duty_a   (right_duty_a),
        .duty_b   (right_duty_b)
    );

    dwpd_wheel u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .gains    (gains_reg),
        .position (signed'(s_tdata[63:32])),
        .target   (signed'(s_tdata[127:96])),
        .drive    (left_drive),
        .duty_a   (left_duty_a),
        .duty_b   (left_duty_b)
    );

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {6'b0, left_duty_b, left_duty_a, right_duty_b, right_duty_a,
                       left_drive, right_drive};

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("accepted request did not enter stage 1");

    a_stage2_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && advance) |=> m_tvalid)
        else $error("stage 2 item lost before output");

    a_right_duty_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (right_drive != '0)) |->
            ((right_duty_a == DUTY_FULL) || (right_duty_b == DUTY_FULL)))
        else $error("right duties do not follow nonzero drive");

    a_left_duty_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (left_drive != '0)) |->
            ((left_duty_a == DUTY_FULL) || (left_duty_b == DUTY_FULL)))
        else $error("left duties do not follow nonzero drive");

endmodule

// File: sim/tb.sv
// Testbench for the dual wheel PID drive: directed table, random phases, self-checking.
`timescale 1ns / 100ps

module tb;
    import dwpd_pkg::*;

    localparam int RIGHT = 0;
    localparam int LEFT = 1;
    localparam int PHASES = 8;
    localparam int PHASE_TICKS = 130;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct {
        logic signed [POS_W-1:0] right_position;
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] right_target;
        logic signed [POS_W-1:0] left_target;
    } tick_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] left_drive;
        logic [DUTY_W-1:0]         right_duty_a;
        logic [DUTY_W-1:0]         right_duty_b;
        logic [DUTY_W-1:0]         left_duty_a;
        logic [DUTY_W-1:0]         left_duty_b;
    } drive_out_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        tick_t                 tick;
        bit                    literal;
        drive_out_t            want;
    } step_row_t;

    typedef struct {
        longint            last_pos;
        longint            integ;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
    } wheel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // right_position, left_position, right_target, left_target
    logic [127:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // right_drive, left_drive, right_duty_a, right_duty_b, left_duty_a, left_duty_b, pad
    logic [55:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gains_t                  gains;
    wheel_t                  wheels [2];
    drive_out_t              pending_drives [$];
    step_row_t               steps [$];
    logic signed [POS_W-1:0] track_pos [2];
    logic signed [POS_W-1:0] track_tgt [2];
    int                      errors = 0;
    int                      results_seen = 0;
    int                      cycle_count;
    bit                      quiet;

    dual_wheel_pid_pwm_drive i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        case (index)
            REG_P_GAIN:    gains.proportional_gain = value[GAIN_W-1:0];
            REG_I_GAIN:    gains.integral_gain = value[GAIN_W-1:0];
            REG_D_GAIN:    gains.derivative_gain = value[GAIN_W-1:0];
            REG_I_LIMIT:   gains.integral_limit = value[ILIM_W-1:0];
            REG_OUT_LIMIT: gains.output_limit = value[OLIM_W-1:0];
            default:       ;
        endcase
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint wheel_law(int w, longint pos, longint tgt);
        longint vel;
        longint err;
        longint sum;
        longint pg;
        longint ig;
        longint dg;
        longint ilim;
        longint olim;
        pg = longint'(gains.proportional_gain);
        ig = longint'(gains.integral_gain);
        dg = longint'(gains.derivative_gain);
        ilim = longint'(gains.integral_limit);
        olim = longint'(gains.output_limit);
        vel = wheels[w].last_pos - pos;
        err = pos - tgt;
        wheels[w].last_pos = pos;
        wheels[w].integ = clip(wheels[w].integ + err * ig, ilim);
        // SV division truncates toward zero
        sum = clip((err * pg + wheels[w].integ - vel * dg) / 8, olim);
        if (sum > 0)
        begin
            wheels[w].duty_a = DUTY_FULL - sum[DUTY_W-1:0];
            wheels[w].duty_b = DUTY_FULL;
        end
        else if (sum < 0)
        begin
            wheels[w].duty_a = DUTY_FULL;
            wheels[w].duty_b = DUTY_FULL + sum[DUTY_W-1:0];
        end
        return sum;
    endfunction

    function automatic drive_out_t control_tick(tick_t t);
        drive_out_t r;
        longint rd;
        longint ld;
        rd = wheel_law(RIGHT, longint'(t.right_position), longint'(t.right_target));
        ld = wheel_law(LEFT, longint'(t.left_position), longint'(t.left_target));
        r.right_drive = rd[DRIVE_W-1:0];
        r.left_drive = ld[DRIVE_W-1:0];
        r.right_duty_a = wheels[RIGHT].duty_a;
        r.right_duty_b = wheels[RIGHT].duty_b;
        r.left_duty_a = wheels[LEFT].duty_a;
        r.left_duty_b = wheels[LEFT].duty_b;
        return r;
    endfunction

    // ---------------- directed table ----------------

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        step_row_t row;
        row.kind = ROW_CFG;
        row.index = index;
        row.value = value;
        row.tick = '{default: '0};
        row.literal = 1'b0;
        row.want = '{default: '0};
        steps.push_back(row);
    endfunction

    function automatic void add_tick(bit literal, logic signed [31:0] rp, logic signed [31:0] lp,
                                     logic signed [31:0] rt, logic signed [31:0] lt,
                                     int rd, int ld, int ra, int rb, int la, int lb);
        step_row_t row;
        row.kind = ROW_TICK;
        row.index = '0;
        row.value = '0;
        row.tick = '{rp, lp, rt, lt};
        row.literal = literal;
        row.want = '{rd[DRIVE_W-1:0], ld[DRIVE_W-1:0], ra[7:0], rb[7:0], la[7:0], lb[7:0]};
        steps.push_back(row);
    endfunction

    function automatic void build_table();
        // idle wheels: zero drive, duties still at their reset value
        add_tick(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tick(1'b0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        // largest position errors saturate both drives in opposite senses
        add_tick(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                 150, -150, 105, 255, 255, 105);
        add_tick(1'b1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                 -150, 150, 255, 105, 105, 255);
        // zero output limit: drive forced to zero, duties held
        add_cfg(REG_OUT_LIMIT, '0);
        add_tick(1'b1, 5, -7, -3, 9, 0, 0, 255, 105, 105, 255);
        add_cfg(REG_OUT_LIMIT, 15'd255);
        add_tick(1'b0, 5, -7, 5, -7, 0, 0, 0, 0, 0, 0);
        add_cfg(REG_I_LIMIT, '0);
        add_tick(1'b0, 100, -100, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cfg(REG_I_LIMIT, 15'h7FFF);
        // data wider than the gain registers keeps the low bits only
        add_cfg(REG_P_GAIN, 15'h7FFF);
        add_cfg(REG_I_GAIN, 15'h7FFF);
        add_cfg(REG_D_GAIN, 15'h7FFF);
        add_tick(1'b0, 3, -2, 0, 0, 0, 0, 0, 0, 0, 0);
        // unused indexes must not touch any register
        add_cfg(CFG_IDX_W'(REG_OUT_LIMIT + 1), '0);
        add_cfg(CFG_IDX_W'(REG_OUT_LIMIT + 3), '0);
        add_tick(1'b0, -1, 1, 2, -2, 0, 0, 0, 0, 0, 0);
        add_cfg(REG_P_GAIN, '0);
        add_cfg(REG_I_GAIN, '0);
        add_cfg(REG_D_GAIN, '0);
        add_tick(1'b0, 50, 50, 0, 0, 0, 0, 0, 0, 0, 0);
    endfunction

    // ---------------- random stimulus ----------------

    function automatic tick_t next_tick();
        tick_t t;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            t = '{$urandom, $urandom, $urandom, $urandom};
        end
        else if (mode == 1)
        begin
            t.right_position = $urandom;
            t.left_position = $urandom;
            t.right_target = t.right_position + int'($urandom_range(0, 40)) - 20;
            t.left_target = t.left_position + int'($urandom_range(0, 40)) - 20;
        end
        else
        begin
            // wheels follow slowly moving targets
            for (int w = 0; w < 2; w++)
            begin
                track_tgt[w] = track_tgt[w] + int'($urandom_range(0, 16)) - 8;
                if ($urandom_range(0, 3) == 0)
                    track_pos[w] = track_tgt[w];
                else
                    track_pos[w] = track_pos[w] + int'($urandom_range(0, 12)) - 6;
            end
            t = '{track_pos[RIGHT], track_pos[LEFT], track_tgt[RIGHT], track_tgt[LEFT]};
        end
        return t;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        logic [GAIN_W-1:0] g;
        logic [2:0] junk;
        g = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(0, 4095))
                                        : GAIN_W'($urandom_range(0, 300));
        junk = 3'($urandom_range(0, 7));
        return {junk, g};
    endfunction

    // ---------------- driving ----------------

    task automatic set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        apply_reg(index, value);
    endtask

    task automatic load_phase(int phase);
        logic [CFG_DATA_W-1:0] v [5];
        case (phase)
            0: v = '{CFG_DATA_W'(RESET_P_GAIN), CFG_DATA_W'(RESET_I_GAIN),
                     CFG_DATA_W'(RESET_D_GAIN), CFG_DATA_W'(RESET_I_LIMIT),
                     CFG_DATA_W'(RESET_OUT_LIMIT)};
            1: v = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF};
            2: v = '{15'd1, 15'd0, 15'd1, 15'd0, 15'd1};
            default:
            begin
                v[0] = rand_gain();
                v[1] = rand_gain();
                v[2] = rand_gain();
                v[3] = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 32767))
                                                    : CFG_DATA_W'($urandom_range(0, 2000));
                v[4] = {7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))};
            end
        endcase
        set_reg(REG_P_GAIN, v[0]);
        set_reg(REG_I_GAIN, v[1]);
        set_reg(REG_D_GAIN, v[2]);
        set_reg(REG_I_LIMIT, v[3]);
        set_reg(REG_OUT_LIMIT, v[4]);
        set_reg(CFG_IDX_W'(REG_OUT_LIMIT + 1 + $urandom_range(0, 2)),
                CFG_DATA_W'($urandom_range(0, 32767)));
        cfg_we <= 1'b0;
        for (int w = 0; w < 2; w++)
        begin
            track_pos[w] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 1000);
            track_tgt[w] = track_pos[w];
        end
    endtask

    task automatic send_tick(tick_t t, bit literal, drive_out_t want);
        drive_out_t pred;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.left_target, t.right_target, t.left_position, t.right_position};
        do @(posedge clk); while (!s_tready);
        pred = control_tick(t);
        pending_drives.push_back(literal ? want : pred);
    endtask

    // stop offering and wait until every request has returned
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_drives.size() != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        gains = '{RESET_P_GAIN, RESET_I_GAIN, RESET_D_GAIN, RESET_I_LIMIT, RESET_OUT_LIMIT};
        wheels[RIGHT] = '{default: '0};
        wheels[LEFT] = '{default: '0};
        build_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < steps.size(); r++)
        begin
            if (steps[r].kind == ROW_CFG)
            begin
                if (r == 0 || steps[r - 1].kind != ROW_CFG)
                    drain();
                set_reg(steps[r].index, steps[r].value);
                if (r + 1 == steps.size() || steps[r + 1].kind != ROW_CFG)
                    cfg_we <= 1'b0;
            end
            else
            begin
                send_tick(steps[r].tick, steps[r].literal, steps[r].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == PHASES - 1)
                quiet <= 1'b1;
            load_phase(p);
            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick(next_tick(), 1'b0, '{default: '0});
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // ---------------- result side ----------------

    initial
    begin : result_ready
        bit held_once;
        held_once = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_once && results_seen >= HOLD_AFTER)
            begin
                // long stall so the pipeline fills and backs up the input
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        drive_out_t got;
        drive_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.right_drive = m_tdata[8:0];
            got.left_drive = m_tdata[17:9];
            got.right_duty_a = m_tdata[25:18];
            got.right_duty_b = m_tdata[33:26];
            got.left_duty_a = m_tdata[41:34];
            got.left_duty_b = m_tdata[49:42];
            results_seen <= results_seen + 1;
            if (pending_drives.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_drives.pop_front();
                check_field("right_drive", int'(want.right_drive), int'(got.right_drive));
                check_field("left_drive", int'(want.left_drive), int'(got.left_drive));
                check_field("right_duty_a", int'(want.right_duty_a), int'(got.right_duty_a));
                check_field("right_duty_b", int'(want.right_duty_b), int'(got.right_duty_b));
                check_field("left_duty_a", int'(want.left_duty_a), int'(got.left_duty_a));
                check_field("left_duty_b", int'(want.left_duty_b), int'(got.left_duty_b));
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

endmodule

// File: dual_wheel_pid_pwm_drive.f
design/dwpd_pkg.sv
design/dwpd_wheel.sv
design/dual_wheel_pid_pwm_drive.sv
sim/tb.sv
